[sv/assert_macros.svh]
// Assertion macros shared by the COBS frame encoder RTL.
// Needs no other file; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_IMP(lbl, clk, rst_n, pre, con, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (con)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define ASSERT_NXT(lbl, clk, rst_n, pre, con, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (con)) \
        else $error(msg);

`endif

[sv/cfe_pkg.sv]
// Package for the COBS frame encoder: widths, constants, item and result types.
// No dependencies; used by cfe_step, cfe_out and cobs_frame_encoder_core.
package cfe_pkg;

    localparam int ADDR_BITS_DEF = 16;
    localparam int OUT_ADDR_W    = 16;
    localparam int BYTE_W        = 8;
    localparam int LEN_W         = 16;
    localparam int CFG_W         = 16;
    localparam int MAX_RES       = 3;
    localparam int RES_CNT_W     = 2;

    localparam logic [BYTE_W-1:0] RUN_MAX   = 8'hFF;
    localparam logic [BYTE_W-1:0] RUN_START = 8'h01;
    localparam logic [CFG_W-1:0]  CFG_RESET = 16'hFFFF;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              has_byte;
        logic              frame_end;
    } t_item;

    typedef struct packed {
        logic [OUT_ADDR_W-1:0] write_addr;
        logic [BYTE_W-1:0]     write_byte;
        logic                  error;
        logic                  frame_done;
        logic [LEN_W-1:0]      frame_length;
    } t_result;

    typedef struct packed {
        logic [RES_CNT_W-1:0]  cnt;
        t_result [MAX_RES-1:0] rec;
    } t_bank;

    function automatic t_result make_write(logic [OUT_ADDR_W-1:0] addr,
                                           logic [BYTE_W-1:0] data,
                                           logic done,
                                           logic [LEN_W-1:0] len);
        t_result r;
        r.write_addr   = addr;
        r.write_byte   = data;
        r.error        = 1'b0;
        r.frame_done   = done;
        r.frame_length = len;
        return r;
    endfunction

    function automatic t_result make_error();
        t_result r;
        r              = '0;
        r.error        = 1'b1;
        return r;
    endfunction

endpackage

[sv/cobs_frame_encoder_core.sv]
// COBS frame encoder: input register, encoder step, result bank with output register.
// An accepted beat waits in the input register until the result bank is free to take it.
// One beat per cycle while beats yield at most one result and i_stall is low; a beat with
// k > 1 results (code writes, frame end, error) holds the next until its last result is taken.
// Reset (synchronous, active low) closes any frame, empties all stages, sets the limit to 65535.
module cobs_frame_encoder_core #(
    parameter int ADDR_BITS = cfe_pkg::ADDR_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [cfe_pkg::BYTE_W-1:0]     i_data_byte,
    input  logic                           i_has_byte,
    input  logic                           i_frame_end,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [cfe_pkg::OUT_ADDR_W-1:0] o_write_addr,
    output logic [cfe_pkg::BYTE_W-1:0]     o_write_byte,
    output logic                           o_error,
    output logic                           o_frame_done,
    output logic [cfe_pkg::LEN_W-1:0]      o_frame_length,
    output logic                           o_last_of_item,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [cfe_pkg::CFG_W-1:0]      i_cfg_data
);

    logic                      r_in_valid;
    cfe_pkg::t_item            r_item;
    logic [cfe_pkg::CFG_W-1:0] r_max_out_len;
    logic                      out_free;
    logic                      advance;
    logic                      accept;
    cfe_pkg::t_bank            bank;
    cfe_pkg::t_result          rec;

    assign advance     = r_in_valid && out_free;
    assign o_stall     = r_in_valid && !out_free;
    assign accept      = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.data_byte <= i_data_byte;
            r_item.has_byte  <= i_has_byte;
            r_item.frame_end <= i_frame_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_out_len <= cfe_pkg::CFG_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_max_out_len <= i_cfg_data;
        end
    end

    cfe_step #(
        .ADDR_BITS(ADDR_BITS)
    ) u_step (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (advance),
        .i_item       (r_item),
        .i_max_out_len(r_max_out_len),
        .o_bank       (bank)
    );

    cfe_out u_out (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_load (advance),
        .i_bank (bank),
        .i_stall(i_stall),
        .o_valid(o_valid),
        .o_rec  (rec),
        .o_last (o_last_of_item),
        .o_free (out_free)
    );

    assign o_write_addr   = rec.write_addr;
    assign o_write_byte   = rec.write_byte;
    assign o_error        = rec.error;
    assign o_frame_done   = rec.frame_done;
    assign o_frame_length = rec.frame_length;

endmodule

[sv/cfe_step.sv]
// Encoder state and the per-beat COBS step that yields up to three results.
// Depends on cfe_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cfe_step #(
    parameter int ADDR_BITS = cfe_pkg::ADDR_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_advance,
    input  cfe_pkg::t_item            i_item,
    input  logic [cfe_pkg::CFG_W-1:0] i_max_out_len,
    output cfe_pkg::t_bank            o_bank
);

    localparam int CMP_W = ((ADDR_BITS > cfe_pkg::CFG_W) ? ADDR_BITS : cfe_pkg::CFG_W) + 1;
    localparam logic [CMP_W-1:0] AMAX = (CMP_W'(1) << ADDR_BITS) - CMP_W'(1);

    logic [ADDR_BITS-1:0]        r_code_slot, n_code_slot;
    logic [ADDR_BITS-1:0]        r_next_slot, n_next_slot;
    logic [cfe_pkg::BYTE_W-1:0]  r_run_code, n_run_code;
    logic                        r_in_frame, n_in_frame;
    logic                        r_discarding, n_discarding;

    logic [CMP_W-1:0]            lim;
    logic                        fail;
    logic [cfe_pkg::RES_CNT_W-1:0] cnt;
    cfe_pkg::t_result [cfe_pkg::MAX_RES-1:0] recs;

    assign lim = (CMP_W'(i_max_out_len) < AMAX) ? CMP_W'(i_max_out_len) : AMAX;

    always_comb begin
        n_code_slot  = r_code_slot;
        n_next_slot  = r_next_slot;
        n_run_code   = r_run_code;
        n_in_frame   = r_in_frame;
        n_discarding = r_discarding;
        fail         = 1'b0;
        cnt          = '0;
        recs         = '0;
        if (r_discarding) begin
            if (i_item.frame_end) begin
                n_discarding = 1'b0;
                n_in_frame   = 1'b0;
            end
        end else begin
            if (!r_in_frame) begin
                n_in_frame  = 1'b1;
                n_code_slot = '0;
                n_next_slot = ADDR_BITS'(1);
                n_run_code  = cfe_pkg::RUN_START;
                if (lim == '0) fail = 1'b1;
            end
            if (!fail && i_item.has_byte) begin
                if (i_item.data_byte == '0) begin
                    if (CMP_W'(n_code_slot) >= lim) begin
                        fail = 1'b1;
                    end else begin
                        recs[cnt] = cfe_pkg::make_write(cfe_pkg::OUT_ADDR_W'(n_code_slot),
                                                        n_run_code, 1'b0, '0);
                        cnt = cnt + 2'd1;
                        n_code_slot = n_next_slot;
                        if (CMP_W'(n_next_slot) + CMP_W'(1) > lim) begin
                            fail = 1'b1;
                        end else begin
                            n_next_slot = n_next_slot + ADDR_BITS'(1);
                            n_run_code  = cfe_pkg::RUN_START;
                        end
                    end
                end else begin
                    if (CMP_W'(n_next_slot) >= lim) begin
                        fail = 1'b1;
                    end else begin
                        recs[cnt] = cfe_pkg::make_write(cfe_pkg::OUT_ADDR_W'(n_next_slot),
                                                        i_item.data_byte, 1'b0, '0);
                        cnt = cnt + 2'd1;
                        n_next_slot = n_next_slot + ADDR_BITS'(1);
                        n_run_code  = n_run_code + 8'd1;
                        if (n_run_code == cfe_pkg::RUN_MAX) begin
                            if (CMP_W'(n_code_slot) >= lim) begin
                                fail = 1'b1;
                            end else begin
                                recs[cnt] = cfe_pkg::make_write(
                                    cfe_pkg::OUT_ADDR_W'(n_code_slot), n_run_code, 1'b0, '0);
                                cnt = cnt + 2'd1;
                                n_code_slot = n_next_slot;
                                if (CMP_W'(n_next_slot) + CMP_W'(1) > lim) begin
                                    fail = 1'b1;
                                end else begin
                                    n_next_slot = n_next_slot + ADDR_BITS'(1);
                                    n_run_code  = cfe_pkg::RUN_START;
                                end
                            end
                        end
                    end
                end
            end
            if (!fail && i_item.frame_end) begin
                if (CMP_W'(n_code_slot) >= lim) begin
                    fail = 1'b1;
                end else begin
                    recs[cnt] = cfe_pkg::make_write(cfe_pkg::OUT_ADDR_W'(n_code_slot),
                                                    n_run_code, 1'b1,
                                                    cfe_pkg::LEN_W'(n_next_slot));
                    cnt = cnt + 2'd1;
                    n_in_frame = 1'b0;
                end
            end
            if (fail) begin
                recs[cnt] = cfe_pkg::make_error();
                cnt = cnt + 2'd1;
                if (i_item.frame_end) begin
                    n_in_frame   = 1'b0;
                    n_discarding = 1'b0;
                end else begin
                    n_discarding = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_slot  <= '0;
            r_next_slot  <= '0;
            r_run_code   <= cfe_pkg::RUN_START;
            r_in_frame   <= 1'b0;
            r_discarding <= 1'b0;
        end else if (i_advance) begin
            r_code_slot  <= n_code_slot;
            r_next_slot  <= n_next_slot;
            r_run_code   <= n_run_code;
            r_in_frame   <= n_in_frame;
            r_discarding <= n_discarding;
        end
    end

    assign o_bank.cnt = cnt;
    assign o_bank.rec = recs;

    `ASSERT_IMP(a_discard_silent, i_clk, i_rst_n, i_advance && r_discarding, cnt == '0,
        "beat emitted results while discarding")
    `ASSERT_NXT(a_end_closes, i_clk, i_rst_n, i_advance && i_item.frame_end, !r_in_frame,
        "frame still open after end beat")

endmodule

[sv/cfe_out.sv]
// Result bank and output register: hands out a beat's results one per cycle unless stalled.
// Depends on cfe_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cfe_out (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  cfe_pkg::t_bank   i_bank,
    input  logic             i_stall,
    output logic             o_valid,
    output cfe_pkg::t_result o_rec,
    output logic             o_last,
    output logic             o_free
);

    cfe_pkg::t_result [cfe_pkg::MAX_RES-1:0] r_res;
    logic [cfe_pkg::RES_CNT_W-1:0]           r_cnt;
    logic [cfe_pkg::RES_CNT_W-1:0]           r_rd;
    logic                                    take;

    assign o_valid = (r_cnt != '0);
    assign take    = o_valid && !i_stall;
    assign o_free  = (r_cnt == '0) || ((r_cnt == 2'd1) && !i_stall);
    assign o_rec   = r_res[r_rd];
    assign o_last  = (r_cnt == 2'd1);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_bank.rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_rd  <= '0;
        end else if (i_load) begin
            r_cnt <= i_bank.cnt;
            r_rd  <= '0;
        end else if (take) begin
            r_cnt <= r_cnt - 2'd1;
            r_rd  <= r_rd + 2'd1;
        end
    end

    `ASSERT_IMP(a_error_last, i_clk, i_rst_n, o_valid && o_rec.error, o_last,
        "error result is not last of its beat")
    `ASSERT_IMP(a_done_last, i_clk, i_rst_n, o_valid && o_rec.frame_done, o_last,
        "final code write is not last of its beat")
    `ASSERT_NXT(a_bank_drain, i_clk, i_rst_n, take && (r_cnt > 2'd1), o_valid,
        "result bank lost pending results")

endmodule
